### src/text_cell_glyph_renderer_unit_defines.svh
// assertion macros used by the glyph renderer row generator
`ifndef TEXT_CELL_GLYPH_RENDERER_UNIT_DEFINES_SVH
`define TEXT_CELL_GLYPH_RENDERER_UNIT_DEFINES_SVH

// checked only while out of reset
`define TCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define TCG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/tcg_pkg.sv
// types, constants and lookup tables of the text cell glyph renderer
package tcg_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 30;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CODE_NUL       = 8'h00;
  localparam logic [7:0] CODE_LF        = 8'h0A;
  localparam logic [7:0] CODE_CR        = 8'h0D;
  localparam logic [7:0] CODE_BOX_BASE  = 8'h80;
  localparam logic [7:0] CODE_HORZ      = 8'hC4;
  localparam logic [7:0] CODE_VERT      = 8'hB3;
  localparam logic [7:0] CODE_DOWN_RIGHT = 8'hDA;
  localparam logic [7:0] CODE_DOWN_LEFT  = 8'hBF;
  localparam logic [7:0] CODE_UP_RIGHT   = 8'hC0;
  localparam logic [7:0] CODE_UP_LEFT    = 8'hD9;

  localparam logic CFG_FG_INDEX = 1'b0;
  localparam logic CFG_BG_INDEX = 1'b1;

  localparam logic [3:0] FG_RESET = 4'd7;
  localparam logic [3:0] BG_RESET = 4'd0;

  // pixel line numbers within the 16 line cell
  localparam logic [3:0] FONT_TOP = 4'd4;
  localparam logic [3:0] FONT_END = 4'd11;
  localparam logic [3:0] BOX_MID  = 4'd8;
  localparam logic [3:0] ROW_LAST = 4'd15;

  typedef enum logic [2:0] {
    BOX_NONE,
    BOX_HORZ,
    BOX_VERT,
    BOX_DOWN_RIGHT,
    BOX_DOWN_LEFT,
    BOX_UP_RIGHT,
    BOX_UP_LEFT
  } box_e;

  // seven font lines, element 0 is the top line
  typedef logic [0:6][7:0] glyph_t;

  typedef struct packed {
    logic [6:0] slot;
    logic [6:0] column;
    logic [4:0] line;
    logic       is_box;
    box_e       box;
    glyph_t     glyph;
    logic [3:0] fg_index;
    logic [3:0] bg_index;
  } entry_t;

  typedef struct packed {
    logic [6:0]  out_slot;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [7:0]  row_pixels;
    logic [15:0] foreground_rgba;
    logic [15:0] background_rgba;
    logic        last_row;
  } row_t;

  function automatic logic [15:0] palette(input logic [3:0] idx);
    logic [15:0] c;
    case (idx)
      4'd0:    c = 16'h000F;
      4'd1:    c = 16'h00AF;
      4'd2:    c = 16'h0A0F;
      4'd3:    c = 16'h0AAF;
      4'd4:    c = 16'hA00F;
      4'd5:    c = 16'hA0AF;
      4'd6:    c = 16'hA50F;
      4'd7:    c = 16'hAAAF;
      4'd8:    c = 16'h555F;
      4'd9:    c = 16'h55FF;
      4'd10:   c = 16'h5F5F;
      4'd11:   c = 16'h5FFF;
      4'd12:   c = 16'hF55F;
      4'd13:   c = 16'hF5FF;
      4'd14:   c = 16'hFF5F;
      default: c = 16'hFFFF;
    endcase
    return c;
  endfunction

  function automatic box_e box_kind(input logic [7:0] code);
    box_e k;
    case (code)
      CODE_HORZ:       k = BOX_HORZ;
      CODE_VERT:       k = BOX_VERT;
      CODE_DOWN_RIGHT: k = BOX_DOWN_RIGHT;
      CODE_DOWN_LEFT:  k = BOX_DOWN_LEFT;
      CODE_UP_RIGHT:   k = BOX_UP_RIGHT;
      CODE_UP_LEFT:    k = BOX_UP_LEFT;
      default:         k = BOX_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] box_row(input box_e kind, input logic [3:0] r);
    logic [7:0] m;
    case (kind)
      BOX_HORZ:       m = (r == BOX_MID) ? 8'hFF : 8'h00;
      BOX_VERT:       m = 8'h08;
      BOX_DOWN_RIGHT: m = (r == BOX_MID) ? 8'h0F : ((r > BOX_MID) ? 8'h08 : 8'h00);
      BOX_DOWN_LEFT:  m = (r == BOX_MID) ? 8'hF8 : ((r > BOX_MID) ? 8'h08 : 8'h00);
      BOX_UP_RIGHT:   m = (r == BOX_MID) ? 8'h0F : ((r < BOX_MID) ? 8'h08 : 8'h00);
      BOX_UP_LEFT:    m = (r == BOX_MID) ? 8'hF8 : ((r < BOX_MID) ? 8'h08 : 8'h00);
      default:        m = 8'h00;
    endcase
    return m;
  endfunction

  // 6x7 font; codes without a glyph fall back to the question mark
  function automatic glyph_t font_glyph(input logic [6:0] code);
    glyph_t g;
    case (code)
      7'h30: g = 56'h1E_21_23_25_29_31_1E;
      7'h31: g = 56'h04_0C_04_04_04_04_0E;
      7'h32: g = 56'h1E_21_01_06_18_20_3F;
      7'h33: g = 56'h1E_21_01_0E_01_21_1E;
      7'h34: g = 56'h02_06_0A_12_3F_02_02;
      7'h35: g = 56'h3F_20_3E_01_01_21_1E;
      7'h36: g = 56'h0E_10_20_3E_21_21_1E;
      7'h37: g = 56'h3F_01_02_04_08_10_10;
      7'h38: g = 56'h1E_21_21_1E_21_21_1E;
      7'h39: g = 56'h1E_21_21_1F_01_02_1C;
      7'h41: g = 56'h0E_11_21_21_3F_21_21;
      7'h42: g = 56'h3E_21_21_3E_21_21_3E;
      7'h43: g = 56'h1E_21_20_20_20_21_1E;
      7'h44: g = 56'h3C_22_21_21_21_22_3C;
      7'h45: g = 56'h3F_20_20_3E_20_20_3F;
      7'h46: g = 56'h3F_20_20_3E_20_20_20;
      7'h47: g = 56'h1E_21_20_27_21_21_1E;
      7'h48: g = 56'h21_21_21_3F_21_21_21;
      7'h49: g = 56'h0E_04_04_04_04_04_0E;
      7'h4A: g = 56'h07_02_02_02_22_22_1C;
      7'h4B: g = 56'h21_22_24_38_24_22_21;
      7'h4C: g = 56'h20_20_20_20_20_20_3F;
      7'h4D: g = 56'h21_33_2D_21_21_21_21;
      7'h4E: g = 56'h21_31_29_25_23_21_21;
      7'h4F: g = 56'h1E_21_21_21_21_21_1E;
      7'h50: g = 56'h3E_21_21_3E_20_20_20;
      7'h51: g = 56'h1E_21_21_21_25_22_1D;
      7'h52: g = 56'h3E_21_21_3E_24_22_21;
      7'h53: g = 56'h1F_20_20_1E_01_01_3E;
      7'h54: g = 56'h3F_04_04_04_04_04_04;
      7'h55: g = 56'h21_21_21_21_21_21_1E;
      7'h56: g = 56'h21_21_21_21_21_12_0C;
      7'h57: g = 56'h21_21_21_21_2D_33_21;
      7'h58: g = 56'h21_12_0C_0C_0C_12_21;
      7'h59: g = 56'h21_12_0C_04_04_04_04;
      7'h5A: g = 56'h3F_01_02_04_08_10_3F;
      7'h61: g = 56'h00_00_1C_02_1E_22_1E;
      7'h62: g = 56'h20_20_3C_22_22_22_3C;
      7'h63: g = 56'h00_00_1C_20_20_20_1C;
      7'h64: g = 56'h02_02_1E_22_22_22_1E;
      7'h65: g = 56'h00_00_1C_22_3E_20_1C;
      7'h66: g = 56'h0C_10_3C_10_10_10_10;
      7'h67: g = 56'h00_00_1E_22_1E_02_1C;
      7'h68: g = 56'h20_20_3C_22_22_22_22;
      7'h69: g = 56'h08_00_18_08_08_08_1C;
      7'h6A: g = 56'h04_00_0C_04_04_24_18;
      7'h6B: g = 56'h20_24_28_30_28_24_22;
      7'h6C: g = 56'h18_08_08_08_08_08_1C;
      7'h6D: g = 56'h00_00_34_2A_2A_2A_2A;
      7'h6E: g = 56'h00_00_3C_22_22_22_22;
      7'h6F: g = 56'h00_00_1C_22_22_22_1C;
      7'h70: g = 56'h00_00_3C_22_3C_20_20;
      7'h71: g = 56'h00_00_1E_22_1E_02_02;
      7'h72: g = 56'h00_00_2C_30_20_20_20;
      7'h73: g = 56'h00_00_1E_20_1C_02_3C;
      7'h74: g = 56'h10_3C_10_10_10_10_0C;
      7'h75: g = 56'h00_00_22_22_22_26_1A;
      7'h76: g = 56'h00_00_22_22_14_14_08;
      7'h77: g = 56'h00_00_22_2A_2A_2A_14;
      7'h78: g = 56'h00_00_22_14_08_14_22;
      7'h79: g = 56'h00_00_22_22_1E_02_1C;
      7'h7A: g = 56'h00_00_3E_04_08_10_3E;
      7'h2D: g = 56'h00_00_00_1F_00_00_00;
      7'h2E: g = 56'h00_00_00_00_00_0C_0C;
      7'h21: g = 56'h04_04_04_04_04_00_04;
      7'h3A: g = 56'h00_0C_0C_00_0C_0C_00;
      7'h3B: g = 56'h00_18_18_00_18_18_10;
      7'h28: g = 56'h02_04_08_08_08_04_02;
      7'h29: g = 56'h08_04_02_02_02_04_08;
      7'h2F: g = 56'h01_02_04_08_10_20_00;
      7'h5C: g = 56'h20_10_08_04_02_00_00;
      7'h2C: g = 56'h00_00_00_00_0C_0C_08;
      7'h27: g = 56'h04_04_02_00_00_00_00;
      7'h22: g = 56'h0A_0A_04_00_00_00_00;
      7'h3C: g = 56'h04_08_10_20_10_08_04;
      7'h3E: g = 56'h10_08_04_02_04_08_10;
      7'h5B: g = 56'h3C_20_20_20_20_20_3C;
      7'h5D: g = 56'h3C_04_04_04_04_04_3C;
      7'h7B: g = 56'h1C_10_10_20_10_10_1C;
      7'h7D: g = 56'h38_08_08_04_08_08_38;
      7'h2B: g = 56'h00_08_08_3E_08_08_00;
      7'h3D: g = 56'h00_00_3E_00_3E_00_00;
      7'h5F: g = 56'h00_00_00_00_00_00_3E;
      7'h40: g = 56'h1C_22_2E_2A_2E_20_1C;
      7'h23: g = 56'h14_3E_14_14_3E_14_00;
      7'h24: g = 56'h08_1E_28_1C_0A_3C_08;
      7'h25: g = 56'h32_32_04_08_10_26_26;
      7'h26: g = 56'h18_24_28_10_2A_24_1A;
      7'h2A: g = 56'h00_14_08_3E_08_14_00;
      7'h7C: g = 56'h08_08_08_08_08_08_08;
      7'h20: g = 56'h00_00_00_00_00_00_00;
      default: g = 56'h1E_21_01_06_04_00_04;
    endcase
    return g;
  endfunction

endpackage

### src/tcg_if.sv
// request and result channel interfaces of the glyph renderer
interface tcg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [6:0] buffer_slot;

  modport source (output valid, output char_code, output buffer_slot, input ready);
  modport sink   (input valid, input char_code, input buffer_slot, output ready);
endinterface

interface tcg_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  out_slot;
  logic [9:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic [7:0]  row_pixels;
  logic [15:0] foreground_rgba;
  logic [15:0] background_rgba;
  logic        last_row;

  modport source (output valid, output out_slot, output pixel_x, output pixel_y,
                  output row_pixels, output foreground_rgba, output background_rgba,
                  output last_row, input ready);
  modport sink   (input valid, input out_slot, input pixel_x, input pixel_y,
                  input row_pixels, input foreground_rgba, input background_rgba,
                  input last_row, output ready);
endinterface

### src/tcg_front.sv
// request front end: cursor tracking, color registers and glyph classification
module tcg_front #(
  parameter int unsigned COLUMNS = tcg_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcg_pkg::ROWS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tcg_in_if.sink          req_i,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [3:0]      cfg_data_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output tcg_pkg::entry_t q_entry_o
);

  localparam logic [6:0] ColLimit  = 7'(COLUMNS);
  localparam logic [4:0] RowLimit  = 5'(ROWS);
  localparam logic [5:0] RowLimitW = 6'(ROWS);

  logic [6:0] col_q, col_d;
  logic [4:0] line_q, line_d;
  logic [3:0] fg_q, bg_q;
  logic       accept;
  logic       on_screen;
  logic [6:0] col_inc;
  logic [5:0] line_inc;

  assign req_i.ready = q_ready_i;
  assign accept      = req_i.valid && req_i.ready;
  assign on_screen   = (col_q < ColLimit) && (line_q < RowLimit);
  assign col_inc     = col_q + 7'd1;
  assign line_inc    = {1'b0, line_q} + 6'd1;

  always_comb begin
    col_d     = col_q;
    line_d    = line_q;
    q_valid_o = 1'b0;
    if (accept) begin
      if (req_i.char_code == tcg_pkg::CODE_LF) begin
        col_d = '0;
        if (line_q < RowLimit) begin
          line_d = line_inc[4:0];
        end
      end else if (req_i.char_code == tcg_pkg::CODE_CR) begin
        col_d = '0;
      end else if (req_i.char_code != tcg_pkg::CODE_NUL) begin
        // off-screen cursor draws nothing but still advances
        q_valid_o = on_screen;
        if (col_inc >= ColLimit) begin
          col_d  = '0;
          line_d = (line_inc >= RowLimitW) ? '0 : line_inc[4:0];
        end else begin
          col_d = col_inc;
        end
      end
    end
  end

  always_comb begin
    q_entry_o.slot     = req_i.buffer_slot;
    q_entry_o.column   = col_q;
    q_entry_o.line     = line_q;
    q_entry_o.is_box   = (req_i.char_code >= tcg_pkg::CODE_BOX_BASE);
    q_entry_o.box      = tcg_pkg::box_kind(req_i.char_code);
    q_entry_o.glyph    = tcg_pkg::font_glyph(req_i.char_code[6:0]);
    q_entry_o.fg_index = fg_q;
    q_entry_o.bg_index = bg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
    end else begin
      col_q  <= col_d;
      line_q <= line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= tcg_pkg::FG_RESET;
      bg_q <= tcg_pkg::BG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tcg_pkg::CFG_FG_INDEX: fg_q <= cfg_data_i;
        tcg_pkg::CFG_BG_INDEX: bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

### src/tcg_queue.sv
// short queue of classified cells between front end and row generator
module tcg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  tcg_pkg::entry_t push_entry_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output tcg_pkg::entry_t pop_entry_o
);

  localparam int unsigned Depth = tcg_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam logic [AW-1:0] PtrLast = AW'(Depth - 1);
  localparam logic [CW-1:0] CntFull = CW'(Depth);

  tcg_pkg::entry_t mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### src/tcg_back.sv
// row generator: walks the sixteen pixel lines of a queued cell
`include "text_cell_glyph_renderer_unit_defines.svh"

module tcg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  tcg_pkg::entry_t q_entry_i,
  tcg_out_if.source       res_o
);

  tcg_pkg::entry_t ent_q, ent_d;
  tcg_pkg::row_t   out_q, row;
  logic            busy_q, busy_d;
  logic [3:0]      r_q, r_d;
  logic            out_valid_q, out_valid_d;
  logic            out_adv;
  logic            finishing;
  logic            q_pop;
  logic [2:0]      gl_idx;
  logic [7:0]      mask;
  logic [3:0]      gl_off;

  assign out_adv   = !out_valid_q || res_o.ready;
  assign finishing = busy_q && out_adv && (r_q == tcg_pkg::ROW_LAST);
  assign q_ready_o = !busy_q || finishing;
  assign q_pop     = q_valid_i && q_ready_o;
  assign gl_off    = r_q - tcg_pkg::FONT_TOP;
  assign gl_idx    = gl_off[2:0];

  always_comb begin
    mask = '0;
    if (ent_q.is_box) begin
      mask = tcg_pkg::box_row(ent_q.box, r_q);
    end else if (r_q >= tcg_pkg::FONT_TOP && r_q < tcg_pkg::FONT_END) begin
      // font is six columns wide, shifted one pixel right in the cell
      mask = {1'b0, ent_q.glyph[gl_idx][5:0], 1'b0};
    end
  end

  always_comb begin
    row.out_slot        = ent_q.slot;
    row.pixel_x         = {ent_q.column, 3'b000};
    row.pixel_y         = {1'b0, ent_q.line, r_q};
    row.row_pixels      = mask;
    row.foreground_rgba = tcg_pkg::palette(ent_q.fg_index);
    row.background_rgba = tcg_pkg::palette(ent_q.bg_index);
    row.last_row        = (r_q == tcg_pkg::ROW_LAST);
  end

  always_comb begin
    busy_d      = busy_q;
    r_d         = r_q;
    ent_d       = ent_q;
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = busy_q;
    end
    if (busy_q && out_adv) begin
      r_d = r_q + 4'd1;
    end
    if (finishing) begin
      busy_d = 1'b0;
    end
    // next cell starts right behind the last line of this one
    if (q_pop) begin
      busy_d = 1'b1;
      r_d    = '0;
      ent_d  = q_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      r_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      r_q         <= r_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (busy_q && out_adv) begin
      out_q <= row;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.out_slot        = out_q.out_slot;
  assign res_o.pixel_x         = out_q.pixel_x;
  assign res_o.pixel_y         = out_q.pixel_y;
  assign res_o.row_pixels      = out_q.row_pixels;
  assign res_o.foreground_rgba = out_q.foreground_rgba;
  assign res_o.background_rgba = out_q.background_rgba;
  assign res_o.last_row        = out_q.last_row;

  `TCG_ASSERT(a_last_row_line, out_valid_q |-> (out_q.last_row == (out_q.pixel_y[3:0] == tcg_pkg::ROW_LAST)), "last_row does not match cell line")
  `TCG_ASSERT(a_pop_only_free, q_pop |-> (!busy_q || r_q == tcg_pkg::ROW_LAST), "cell taken while previous one unfinished")
  `TCG_ASSERT(a_line_advance, (busy_q && out_adv && r_q != tcg_pkg::ROW_LAST) |=> (busy_q && r_q == $past(r_q) + 4'd1), "cell line walk skipped or stopped")
  `TCG_ASSERT_ALWAYS(a_idle_no_out, (!rst_ni) |=> !out_valid_q, "result valid out of reset")

endmodule

### src/text_cell_glyph_renderer_unit.sv
// text cell glyph renderer top level: front end, cell queue and row generator
//
// req_i takes one character code and framebuffer slot per request. Newline,
// carriage return and NUL only move (or keep) the text cursor and give no
// results. Any other code at an on-screen cursor gives sixteen results on
// res_o, one per pixel line of the 8x16 cell, top line first, last_row set
// on the sixteenth; the cursor then advances and wraps at the last column.
// A drawn character reaches res_o through the cell queue and the row
// generator's cell and output registers. The generator emits one line per
// cycle while res_o is not stalled; a two-entry cell queue lets the front end
// take the next requests meanwhile, and cursor-only requests go at one per
// cycle while the queue has room. When res_o is stalled the current line
// holds, the generator waits, and req_i.ready drops once the queue is full.
// cfg_we_i writes the foreground (index 0) or background (index 1) palette
// index; it is used for characters accepted after the write.
// Reset clears the cursor to the top left, empties the queue and the output,
// and sets foreground index 7 and background index 0.
module text_cell_glyph_renderer_unit #(
  parameter int unsigned COLUMNS = tcg_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcg_pkg::ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcg_in_if.sink     req_i,
  tcg_out_if.source  res_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [3:0] cfg_data_i
);

  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;
  tcg_pkg::entry_t push_entry, pop_entry;

  tcg_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_o   (push_valid),
    .q_ready_i   (push_ready),
    .q_entry_o   (push_entry)
  );

  tcg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  tcg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_ready_o (pop_ready),
    .q_entry_i (pop_entry),
    .res_o     (res_o)
  );

endmodule
